@@ rtl/mntt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mntt_pkg: shared types and constants of the NTT coefficient unit
// Field structs, modulus and store sizes, operation and register codes,
// sequencer states.
// ----------------------------------------------------------------------------
package mntt_pkg;

  // Modulus and store depth
  localparam int unsigned PRIME      = 40961;
  localparam int unsigned MAX_LENGTH = 256;

  // Widths
  localparam int unsigned VAL_W = 16;                     // residues
  localparam int unsigned POS_W = 8;                      // position field
  localparam int unsigned LEN_W = 9;                      // length register
  localparam int unsigned IDX_W = $clog2(MAX_LENGTH);     // store address
  localparam int unsigned NW    = $clog2(MAX_LENGTH + 1); // counts up to depth
  localparam int unsigned CNT_W = $clog2(POS_W);          // remainder steps

  // Barrett reciprocal for products below 2^32
  localparam logic [31:0] BARRETT_REC = 32'((64'd1 << 32) / PRIME);

  // Register reset values
  localparam logic [VAL_W-1:0] TWIDDLE_RST = 16'd36043;
  localparam logic [VAL_W-1:0] NORM_RST    = 16'd38401;
  localparam logic [LEN_W-1:0] LENGTH_RST  = 9'd256;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TWIDDLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORM    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 2'd2;

  // Operation codes
  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_FORWARD = 2'd1;
  localparam logic [1:0] OP_INVERSE = 2'd2;

  typedef struct packed {
    logic [1:0]       operation;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] coefficient;
    logic [POS_W-1:0] out_position;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BLD_INIT,
    ST_BLD_ISSUE,
    ST_BLD_WAIT,
    ST_REM,
    ST_ACC_RUN,
    ST_ACC_DRAIN,
    ST_NORM_ISSUE,
    ST_NORM_WAIT,
    ST_EMIT
  } mntt_state_t;

endpackage
`default_nettype wire

@@ rtl/mntt_modmul.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mntt_modmul: pipelined modular multiplier
// (a * b) mod PRIME through Barrett reduction; four stages, one product
// accepted every cycle.
// ----------------------------------------------------------------------------
module mntt_modmul (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  input  wire logic [mntt_pkg::VAL_W-1:0] a,
  input  wire logic [mntt_pkg::VAL_W-1:0] b,
  output logic                           out_valid,
  output logic [mntt_pkg::VAL_W-1:0]     res
);
  import mntt_pkg::*;

  logic        v1, v2, v3;
  logic [31:0] prod1, prod2, prod3;
  logic [31:0] q2;
  logic [31:0] qp3;
  logic [63:0] q_full;
  logic [31:0] r_raw;
  logic [31:0] r_red;

  assign q_full = 64'(prod1) * 64'(BARRETT_REC);
  assign r_raw  = prod3 - qp3;
  // estimate is low by at most one, so a single correction suffices
  assign r_red  = (r_raw >= 32'(PRIME)) ? r_raw - 32'(PRIME) : r_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    prod1 <= 32'(a) * 32'(b);
    q2    <= q_full[63:32];
    prod2 <= prod1;
    qp3   <= q2 * 32'(PRIME);
    prod3 <= prod2;
    res   <= r_red[VAL_W-1:0];
  end

endmodule
`default_nettype wire

@@ rtl/modular_ntt_coefficient_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// modular_ntt_coefficient_unit: direct-form NTT, one coefficient per query
// Stores residue samples and returns norm * sum x_j * w^e(j,k) mod PRIME
// for a queried output index, forward or inverse.
// ----------------------------------------------------------------------------
//
//   channel  signals                          direction  transfer when
//   -------  -------------------------------  ---------  --------------------
//   in       in_valid, in_stall, in_data      into unit  in_valid & !in_stall
//   out      out_valid, out_stall, out_data   from unit  out_valid & !out_stall
//   cfg      cfg_write, cfg_index, cfg_data   into unit  cfg_write
//
// A query over n = min(length, MAX_LENGTH) samples runs eight remainder steps,
// one multiply per sample through the shared multiplier, its drain and one
// normalising multiply. The first query of nonzero length after reset or a
// twiddle write first fills the power table over MAX_LENGTH entries. Reset is
// synchronous; in_stall holds high during a query, and a result waits under out_stall.
// ----------------------------------------------------------------------------
module modular_ntt_coefficient_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire mntt_pkg::in_item_t            in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output mntt_pkg::out_item_t                out_data,
  input  wire logic                          cfg_write,
  input  wire logic [mntt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mntt_pkg::VAL_W-1:0]    cfg_data
);
  import mntt_pkg::*;

  mntt_state_t state, state_next;

  // configuration
  logic [VAL_W-1:0] twiddle;
  logic [VAL_W-1:0] norm_factor;
  logic [LEN_W-1:0] length;
  logic             table_valid;

  // query context
  logic [POS_W-1:0] k;
  logic [POS_W-1:0] k_sh;
  logic             inverse;
  logic [NW-1:0]    n;
  logic [NW-1:0]    rem;
  logic [CNT_W-1:0] rem_cnt;
  logic [NW-1:0]    j;
  logic [NW-1:0]    e;
  logic [NW-1:0]    pend;
  logic [VAL_W-1:0] acc;
  logic [VAL_W-1:0] res_hold;

  // table build
  logic [IDX_W-1:0] b;
  logic [VAL_W-1:0] prev;

  // memories and their read registers
  logic [VAL_W-1:0] sample_store [MAX_LENGTH];
  logic [VAL_W-1:0] power_table  [MAX_LENGTH];
  logic [VAL_W-1:0] sample_rd;
  logic [VAL_W-1:0] power_rd;
  logic             rd_valid;

  // multiplier
  logic             mm_in_valid;
  logic [VAL_W-1:0] mm_a, mm_b;
  logic             mm_valid;
  logic [VAL_W-1:0] mm_res;

  // control
  logic             accept;
  logic             is_query;
  logic             store_we;
  logic             issue;
  logic             take;
  logic             emit_load;
  logic             tbl_we;
  logic [IDX_W-1:0] tbl_waddr;
  logic [VAL_W-1:0] tbl_wdata;
  logic             build_last;

  // datapath helpers
  logic [15:0]      len16;
  logic [NW-1:0]    n_cfg;
  logic [NW:0]      rem_sh;
  logic [NW:0]      rem_next;
  logic [NW:0]      e_sum;
  logic [NW:0]      e_next;
  logic [NW-1:0]    e_exp;
  logic [IDX_W-1:0] e_addr;
  logic [VAL_W:0]   acc_sum;
  logic [VAL_W:0]   acc_next;
  logic [NW-1:0]    pend_next;

  // saturate length to the store depth
  assign len16 = 16'(length);
  assign n_cfg = (len16 > 16'(MAX_LENGTH)) ? NW'(MAX_LENGTH) : NW'(len16);

  // one restoring step of k mod n per cycle
  assign rem_sh   = {rem, k_sh[POS_W-1]};
  assign rem_next = (rem_sh >= {1'b0, n}) ? rem_sh - {1'b0, n} : rem_sh;

  // advance the exponent by k mod n, wrapping at n
  assign e_sum  = {1'b0, e} + {1'b0, rem};
  assign e_next = (e_sum >= {1'b0, n}) ? e_sum - {1'b0, n} : e_sum;
  // inverse direction: negate the exponent mod n
  assign e_exp  = (inverse && (e != '0)) ? n - e : e;
  assign e_addr = IDX_W'(e_exp);

  assign acc_sum  = {1'b0, acc} + {1'b0, mm_res};
  assign acc_next = (acc_sum >= (VAL_W+1)'(PRIME)) ? acc_sum - (VAL_W+1)'(PRIME) : acc_sum;

  assign pend_next = pend + NW'(issue) - NW'(take);

  assign build_last = (b == IDX_W'(MAX_LENGTH - 1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && is_query) begin
          if (n_cfg == '0) begin
            state_next = ST_EMIT;
          end else if (!table_valid) begin
            state_next = ST_BLD_INIT;
          end else begin
            state_next = ST_REM;
          end
        end
      end
      ST_BLD_INIT:  state_next = ST_BLD_ISSUE;
      ST_BLD_ISSUE: state_next = ST_BLD_WAIT;
      ST_BLD_WAIT: begin
        if (mm_valid) begin
          state_next = build_last ? ST_REM : ST_BLD_ISSUE;
        end
      end
      ST_REM: begin
        if (rem_cnt == CNT_W'(POS_W - 1)) begin
          state_next = ST_ACC_RUN;
        end
      end
      ST_ACC_RUN: begin
        if (j == n - NW'(1)) begin
          state_next = ST_ACC_DRAIN;
        end
      end
      ST_ACC_DRAIN: begin
        if (pend == '0) begin
          state_next = ST_NORM_ISSUE;
        end
      end
      ST_NORM_ISSUE: state_next = ST_NORM_WAIT;
      ST_NORM_WAIT: begin
        if (mm_valid) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall    = (state != ST_IDLE);
    accept      = in_valid && (state == ST_IDLE);
    is_query    = (in_data.operation == OP_FORWARD) || (in_data.operation == OP_INVERSE);
    store_we    = accept && (in_data.operation == OP_WRITE)
                  && (16'(in_data.position) < 16'(MAX_LENGTH));
    issue       = (state == ST_ACC_RUN);
    take        = mm_valid && ((state == ST_ACC_RUN) || (state == ST_ACC_DRAIN));
    emit_load   = (state == ST_EMIT) && (!out_valid || !out_stall);
    tbl_we      = 1'b0;
    tbl_waddr   = b;
    tbl_wdata   = mm_res;
    mm_in_valid = rd_valid;
    mm_a        = sample_rd;
    mm_b        = power_rd;
    case (state)
      ST_BLD_INIT: begin
        tbl_we    = 1'b1;
        tbl_waddr = '0;
        tbl_wdata = VAL_W'(1);
      end
      ST_BLD_ISSUE: begin
        mm_in_valid = 1'b1;
        mm_a        = prev;
        mm_b        = twiddle;
      end
      ST_BLD_WAIT: begin
        tbl_we = mm_valid;
      end
      ST_NORM_ISSUE: begin
        mm_in_valid = 1'b1;
        mm_a        = acc;
        mm_b        = norm_factor;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      twiddle     <= TWIDDLE_RST;
      norm_factor <= NORM_RST;
      length      <= LENGTH_RST;
      table_valid <= 1'b0;
      rd_valid    <= 1'b0;
      pend        <= '0;
      out_valid   <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= issue;
      pend     <= pend_next;
      if ((state == ST_BLD_WAIT) && mm_valid && build_last) begin
        table_valid <= 1'b1;
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_TWIDDLE: begin
            twiddle     <= cfg_data;
            table_valid <= 1'b0;   // powers must be rebuilt
          end
          CFG_NORM:   norm_factor <= cfg_data;
          CFG_LENGTH: length      <= cfg_data[LEN_W-1:0];
          default: begin
          end
        endcase
      end
      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept && is_query) begin
      k        <= in_data.position;
      k_sh     <= in_data.position;
      inverse  <= (in_data.operation == OP_INVERSE);
      n        <= n_cfg;
      rem      <= '0;
      rem_cnt  <= '0;
      j        <= '0;
      e        <= '0;
      acc      <= '0;
      res_hold <= '0;
    end
    if (state == ST_BLD_INIT) begin
      prev <= VAL_W'(1);
      b    <= IDX_W'(1);
    end
    if ((state == ST_BLD_WAIT) && mm_valid) begin
      prev <= mm_res;
      b    <= b + IDX_W'(1);
    end
    if (state == ST_REM) begin
      rem     <= rem_next[NW-1:0];
      k_sh    <= {k_sh[POS_W-2:0], 1'b0};
      rem_cnt <= rem_cnt + CNT_W'(1);
    end
    if (issue) begin
      j <= j + NW'(1);
      e <= e_next[NW-1:0];
    end
    if (take) begin
      acc <= acc_next[VAL_W-1:0];
    end
    if ((state == ST_NORM_WAIT) && mm_valid) begin
      res_hold <= mm_res;
    end
    if (emit_load) begin
      out_data.coefficient  <= res_hold;
      out_data.out_position <= k;
    end
  end

  // sample store: written by write transfers, read once per issued term
  always_ff @(posedge clk) begin
    if (store_we) begin
      sample_store[IDX_W'(in_data.position)] <= in_data.sample;
    end
    if (issue) begin
      sample_rd <= sample_store[j[IDX_W-1:0]];
    end
  end

  // power table: w^e for every exponent below the store depth
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      power_table[tbl_waddr] <= tbl_wdata;
    end
    if (issue) begin
      power_rd <= power_table[e_addr];
    end
  end

  mntt_modmul u_modmul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mm_in_valid),
    .a         (mm_a),
    .b         (mm_b),
    .out_valid (mm_valid),
    .res       (mm_res)
  );

endmodule
`default_nettype wire

@@ bench/tb_modular_ntt_coefficient_unit.sv @@
// ----------------------------------------------------------------------------
// tb_modular_ntt_coefficient_unit: self-checking bench for the NTT unit
// Drives sample writes and coefficient queries through the valid/stall
// channel, mirrors the sample store and registers, predicts each coefficient
// from the direct-form sum and compares every output transfer in order.
// ----------------------------------------------------------------------------
module tb_modular_ntt_coefficient_unit;
  import mntt_pkg::*;

  // Operation code that the unit must ignore
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_TWIDDLE;
  logic [VAL_W-1:0]     cfg_data = '0;

  // Requests waiting to be offered, and coefficients owed by the unit
  in_item_t    queued_requests[$];
  out_item_t   due_coefficients[$];
  out_item_t   oldest_due;

  // Mirror of the unit's registers and sample store
  logic [VAL_W-1:0] cur_twiddle = TWIDDLE_RST;
  logic [VAL_W-1:0] cur_norm    = NORM_RST;
  logic [LEN_W-1:0] cur_length  = LENGTH_RST;
  logic [VAL_W-1:0] sample_mirror [MAX_LENGTH];

  // Entries that the generated stimulus has written so far; a query is only
  // issued once every entry it sums has been written
  bit               filled [MAX_LENGTH];

  int unsigned      send_gap_pct = 0;
  int unsigned      stall_pct    = 0;
  int unsigned      error_count  = 0;
  int unsigned      cycle_count  = 0;

  modular_ntt_coefficient_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  function automatic logic [VAL_W-1:0] mulmod(logic [31:0] a, logic [31:0] b);
    logic [63:0] p;
    p = (64'(a) % PRIME) * (64'(b) % PRIME);
    return VAL_W'(p % PRIME);
  endfunction

  // Effective transform length: the register saturates at the store depth
  function automatic int unsigned span_of(logic [LEN_W-1:0] len);
    return (len > MAX_LENGTH) ? MAX_LENGTH : int'(len);
  endfunction

  // norm * sum_j x_j * w^e(j,k) mod PRIME; the inverse direction negates the
  // exponent mod n. An empty sum (length zero) gives zero.
  function automatic logic [VAL_W-1:0] ntt_coefficient(logic [POS_W-1:0] k,
                                                       logic inverse);
    logic [VAL_W-1:0] powers [MAX_LENGTH];
    logic [31:0]      acc;
    int unsigned      n;
    int unsigned      e;
    n = span_of(cur_length);
    if (n == 0) return '0;
    powers[0] = 1;
    for (int unsigned i = 1; i < n; i++) powers[i] = mulmod(powers[i-1], cur_twiddle);
    acc = 0;
    for (int unsigned j = 0; j < n; j++) begin
      e = (j * k) % n;
      if (inverse) e = (n - e) % n;
      acc = (acc + mulmod(sample_mirror[j], powers[e])) % PRIME;
    end
    return mulmod(acc, cur_norm);
  endfunction

  // Apply one accepted request to the mirror; queries owe one coefficient
  function automatic void apply_request(in_item_t req);
    out_item_t owed;
    case (req.operation)
      OP_WRITE: begin
        sample_mirror[req.position] = req.sample;
      end
      OP_FORWARD, OP_INVERSE: begin
        owed.coefficient  = ntt_coefficient(req.position, req.operation == OP_INVERSE);
        owed.out_position = req.position;
        due_coefficients.push_back(owed);
      end
      default: begin
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offer queued requests, holding each until its transfer
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) apply_request(in_data);
      // Advance only once the current request has gone, so a stalled
      // payload never changes and valid is not dropped under a stall
      if (!in_valid || !in_stall) begin
        if (queued_requests.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          in_data  <= queued_requests.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check every output transfer against the oldest owed coefficient
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_coefficients.size() == 0) begin
          $error("unexpected result: coefficient %0d, out_position %0d",
                 out_data.coefficient, out_data.out_position);
          error_count++;
        end else begin
          oldest_due = due_coefficients.pop_front();
          if (out_data.coefficient !== oldest_due.coefficient) begin
            $error("coefficient: expected %0d, actual %0d",
                   oldest_due.coefficient, out_data.coefficient);
            error_count++;
          end
          if (out_data.out_position !== oldest_due.out_position) begin
            $error("out_position: expected %0d, actual %0d",
                   oldest_due.out_position, out_data.out_position);
            error_count++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Watchdog: a hung handshake ends the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Mostly residues, with some values at or above the prime and all-ones
  function automatic logic [VAL_W-1:0] random_sample();
    case ($urandom_range(0, 9))
      0:       return '1;
      1:       return VAL_W'($urandom_range(PRIME, 65535));
      default: return VAL_W'($urandom_range(0, PRIME - 1));
    endcase
  endfunction

  task automatic add(logic [1:0] op, logic [POS_W-1:0] pos, logic [VAL_W-1:0] smp);
    in_item_t req;
    req.operation = op;
    req.position  = pos;
    req.sample    = smp;
    if (op == OP_WRITE) filled[pos] = 1'b1;
    queued_requests.push_back(req);
  endtask

  // Mix of writes, queries and ignored operations. A query that would sum an
  // unwritten entry turns into a write of the lowest such entry instead.
  task automatic add_random(int unsigned count);
    int unsigned      n;
    int unsigned      r;
    int               gap;
    logic [1:0]       op;
    logic [POS_W-1:0] pos;
    n = span_of(cur_length);
    for (int unsigned i = 0; i < count; i++) begin
      r   = $urandom_range(0, 99);
      op  = OP_WRITE;
      pos = POS_W'($urandom_range(0, 255));
      if (r < 30) begin
        if (n != 0) pos = POS_W'($urandom_range(0, n - 1));
      end else if (r >= 40 && r < 92) begin
        gap = -1;
        for (int j = int'(n) - 1; j >= 0; j--) if (!filled[j]) gap = j;
        if (gap < 0) op = $urandom_range(0, 1) ? OP_FORWARD : OP_INVERSE;
        else pos = POS_W'(gap);
      end else if (r >= 92) begin
        op = OP_UNUSED;
      end
      add(op, pos, random_sample());
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      CFG_TWIDDLE: cur_twiddle = value;
      CFG_NORM:    cur_norm    = value;
      CFG_LENGTH:  cur_length  = value[LEN_W-1:0];
      default: begin
      end
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Hold the sender until every request has gone and every owed coefficient
  // has arrived, then let a trailing write finish inside the unit
  task automatic settle();
    while (queued_requests.size() != 0 || in_valid || due_coefficients.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Start a phase from idle: new registers and new idling pattern. Queueing
  // happens on the falling edge, clear of the driver's sampling edge.
  task automatic begin_phase(logic [VAL_W-1:0] tw, logic [VAL_W-1:0] norm,
                             logic [VAL_W-1:0] len, int unsigned gap,
                             int unsigned stall);
    settle();
    write_reg(CFG_TWIDDLE, tw);
    write_reg(CFG_NORM, norm);
    write_reg(CFG_LENGTH, len);
    send_gap_pct = gap;
    stall_pct    = stall;
    @(negedge clk);
  endtask

  // Root of the given power-of-two order, from the reset twiddle of order
  // MAX_LENGTH by repeated squaring
  function automatic logic [VAL_W-1:0] root_of_order(int unsigned n);
    logic [VAL_W-1:0] r;
    int unsigned      m;
    r = TWIDDLE_RST;
    m = MAX_LENGTH;
    while (m > n) begin
      r = mulmod(r, r);
      m = m / 2;
    end
    return r;
  endfunction

  initial begin
    for (int i = 0; i < MAX_LENGTH; i++) begin
      sample_mirror[i] = '0;
      filled[i]        = 1'b0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: extreme samples and positions, both directions, query index
    // beyond the length, ignored operation code, writes beyond the length
    begin_phase(root_of_order(4), 16'd12345, 16'd4, 0, 0);
    add(OP_WRITE, 8'd0, 16'd0);
    add(OP_WRITE, 8'd1, 16'd40960);
    add(OP_WRITE, 8'd2, 16'hFFFF);
    add(OP_WRITE, 8'd3, 16'h5555);
    add(OP_FORWARD, 8'd0, 16'd0);
    add(OP_FORWARD, 8'd1, 16'hFFFF);
    add(OP_FORWARD, 8'd3, 16'd0);
    add(OP_FORWARD, 8'd255, 16'd0);
    add(OP_INVERSE, 8'd0, 16'd0);
    add(OP_INVERSE, 8'd2, 16'd0);
    add(OP_INVERSE, 8'd255, 16'hFFFF);
    add(OP_UNUSED, 8'd0, 16'd0);
    add(OP_UNUSED, 8'd255, 16'hFFFF);
    add(OP_UNUSED, 8'd2, 16'd7);
    add(OP_FORWARD, 8'd2, 16'd0);
    add(OP_WRITE, 8'd255, 16'hAAAA);
    add(OP_WRITE, 8'd128, 16'h1234);
    add(OP_INVERSE, 8'd1, 16'd0);

    // Each phase boundary also holds the sender until nothing is owed
    begin_phase(root_of_order(8), VAL_W'($urandom_range(0, PRIME - 1)), 16'd8, 63, 0);
    add_random(60);

    // Empty sum, twiddle all-ones, zero normalisation
    begin_phase(16'hFFFF, 16'd0, 16'd0, 0, 63);
    add_random(30);

    // Single-sample transform, zero twiddle, normalisation above the prime
    begin_phase(16'd0, 16'hFFFF, 16'd1, 7, 7);
    add_random(50);

    begin_phase(root_of_order(16), VAL_W'($urandom_range(0, PRIME - 1)), 16'd16, 0, 0);
    add_random(60);

    // Length register above the store depth saturates; fill the whole store
    // first, then query over it
    begin_phase(TWIDDLE_RST, NORM_RST, 16'd511, 0, 63);
    for (int j = 0; j < MAX_LENGTH; j++) add(OP_WRITE, POS_W'(j), random_sample());
    add_random(30);

    begin_phase(VAL_W'($urandom_range(0, 65535)), VAL_W'($urandom_range(0, PRIME - 1)),
                16'd256, 63, 0);
    add_random(30);

    // Odd length with an arbitrary twiddle
    begin_phase(VAL_W'($urandom_range(0, 65535)), VAL_W'($urandom_range(0, 65535)),
                16'd3, 7, 7);
    add_random(40);

    settle();
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/mntt_pkg.sv
rtl/mntt_modmul.sv
rtl/modular_ntt_coefficient_unit.sv
bench/tb_modular_ntt_coefficient_unit.sv
